FILE: hdl/nta_pkg.sv
// Package for the number-to-ASCII formatter: op codes, character codes,
// payload and control types, and the digit-to-character function.
// No dependencies; every other file of the block but nta_stream_if imports it.
package nta_pkg;

  localparam int unsigned DEFAULT_VALUE_BITS = 32;
  localparam int unsigned DIGIT_W            = 4;
  localparam int unsigned FRAC_DIGITS        = 3;
  localparam int unsigned OP_W               = 2;
  localparam int unsigned FIELD_W            = 32;
  localparam int unsigned CHAR_W             = 8;

  localparam logic [DIGIT_W-1:0] DEC_RADIX  = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0]  CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_UPF   = 8'h46;

  typedef enum logic [OP_W-1:0] {
    OP_DEC   = 2'd0,
    OP_HEX   = 2'd1,
    OP_FIXED = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       hex;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PREFIX,
    ST_DIGITS,
    ST_DOT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DEC_RADIX) begin
      digit_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end else begin
      digit_char = CHAR_SEVEN + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end
  endfunction

endpackage

FILE: hdl/nta_stream_if.sv
// Valid/ready stream interface used for both channels of the formatter.
// The payload type is a parameter; the block uses the structs of nta_pkg.
interface nta_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/nta_bcd_cell.sv
// One decimal digit cell of the converter row: shift-and-add-3 step,
// parallel load of a nibble or of zero, and a digit shift towards the top. Uses nta_pkg.
module nta_bcd_cell (
  input  logic                    clk_i,
  input  nta_pkg::cell_ctrl_t     ctrl_i,
  input  logic [3:0]              nib_i,
  input  logic [3:0]              prev_i,
  input  logic                    bit_i,
  output logic [3:0]              digit_o,
  output logic                    bit_o
);
  import nta_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  assign adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;

  always_comb begin
    unique case (ctrl_i.mode)
      CELL_HOLD:   digit_d = digit_q;
      CELL_LOAD:   digit_d = ctrl_i.hex ? nib_i : '0;
      CELL_DABBLE: digit_d = {adj[DIGIT_W-2:0], bit_i};
      CELL_SHIFT:  digit_d = prev_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;
  assign bit_o   = adj[DIGIT_W-1];
endmodule

FILE: hdl/nta_cell_row.sv
// Row of digit cells: a serial bit enters the lowest cell and carries move
// up; in shift mode the digits move up one cell. Uses nta_pkg and nta_bcd_cell.
module nta_cell_row #(
  parameter int unsigned NCELL = 10
) (
  input  logic                  clk_i,
  input  nta_pkg::cell_ctrl_t   ctrl_i,
  input  logic                  bit_i,
  input  logic [4*NCELL-1:0]    nib_i,
  output logic [3:0]            top_o
);
  import nta_pkg::*;

  logic [DIGIT_W-1:0] digits [NCELL];
  logic [NCELL-1:0]   carry;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [DIGIT_W-1:0] prev;
    logic               cin;
    if (i == 0) begin : g_low
      assign prev = '0;
      assign cin  = bit_i;
    end else begin : g_up
      assign prev = digits[i-1];
      assign cin  = carry[i-1];
    end
    nta_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .nib_i   (nib_i[DIGIT_W*i +: DIGIT_W]),
      .prev_i  (prev),
      .bit_i   (cin),
      .digit_o (digits[i]),
      .bit_o   (carry[i])
    );
  end

  assign top_o = digits[NCELL-1];
endmodule

FILE: hdl/number_to_ascii_formatter_top.sv
// Top level of the number-to-ASCII formatter: controller, output register
// and the digit cell row. Uses nta_pkg, nta_stream_if and nta_cell_row.
//
// An item on in_i carries an op and a value. Op 0 gives unsigned decimal,
// op 1 gives "0x" and uppercase hex, op 2 gives signed thousandths with a
// '-' for negative values, integer part, '.' and three fraction digits. Op 3 is dropped.
// Each transfer on out_o carries one ASCII character; last marks the end.
// The value is converted by shifting it one bit a cycle through a row of
// decimal digit cells; hex values are loaded as nibbles and skip this step.
// Leading zero cells are then skipped, and one character is offered per
// cycle while the receiver does not stall.
// A new item is taken only when the previous one has handed its last
// character to the output register, which may still hold it.
// If the receiver stalls, the character is held and the controller waits;
// the next item may still be taken and converted meanwhile.
// Reset returns the controller to idle and empties the output register.
module number_to_ascii_formatter_top #(
  parameter int unsigned VALUE_BITS = nta_pkg::DEFAULT_VALUE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nta_stream_if.sink   in_i,
  nta_stream_if.source out_o
);
  import nta_pkg::*;

  localparam int unsigned DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned HEX_DIGITS = (VALUE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned MIN_CELLS  = FRAC_DIGITS + 1;
  localparam int unsigned NC0        = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int unsigned NCELL      = (NC0 > MIN_CELLS) ? NC0 : MIN_CELLS;
  localparam int unsigned REM_W      = $clog2(NCELL + 1);
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic                   neg_q, neg_d;
  logic                   pidx_q, pidx_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0]  conv_q, conv_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic [VALUE_BITS-1:0]  v, mag;
  logic                   v_neg;
  logic                   in_ok;
  logic [DIGIT_W-1:0]     top;
  logic [REM_W-1:0]       min_digits;
  logic                   gen_valid, gen_last, gen_fire;
  logic [CHAR_W-1:0]      gen_char;
  cell_ctrl_t             cell_ctrl;

  assign v     = VALUE_BITS'({{FIELD_W{1'b0}}, in_i.data.value});
  assign v_neg = (in_i.data.op == OP_FIXED) && v[VALUE_BITS-1];
  assign mag   = v_neg ? (VALUE_BITS'(0) - v) : v;
  assign in_ok = (in_i.data.op == OP_DEC) || (in_i.data.op == OP_HEX) ||
                 (in_i.data.op == OP_FIXED);

  assign min_digits = (op_q == OP_FIXED) ? REM_W'(MIN_CELLS) : REM_W'(1);
  assign gen_fire   = gen_valid && (!out_valid_q || out_o.ready);

  nta_cell_row #(
    .NCELL (NCELL)
  ) u_row (
    .clk_i  (clk_i),
    .ctrl_i (cell_ctrl),
    .bit_i  (conv_q[VALUE_BITS-1]),
    .nib_i  ((4*NCELL)'(v)),
    .top_o  (top)
  );

  always_comb begin
    in_i.ready     = 1'b0;
    gen_valid      = 1'b0;
    gen_last       = 1'b0;
    gen_char       = CHAR_ZERO;
    cell_ctrl.mode = CELL_HOLD;
    cell_ctrl.hex  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready     = 1'b1;
        cell_ctrl.mode = CELL_LOAD;
        cell_ctrl.hex  = (in_i.data.op == OP_HEX);
      end
      ST_CONV: begin
        cell_ctrl.mode = CELL_DABBLE;
      end
      ST_SKIP: begin
        if ((top == '0) && (rem_q > min_digits)) begin
          cell_ctrl.mode = CELL_SHIFT;
        end
      end
      ST_PREFIX: begin
        gen_valid = 1'b1;
        if (op_q == OP_HEX) begin
          gen_char = pidx_q ? CHAR_X : CHAR_ZERO;
        end else begin
          gen_char = CHAR_MINUS;
        end
      end
      ST_DIGITS: begin
        gen_valid = 1'b1;
        gen_char  = digit_char(top);
        gen_last  = (rem_q == REM_W'(1));
        if (!out_valid_q || out_o.ready) begin
          cell_ctrl.mode = CELL_SHIFT;
        end
      end
      ST_DOT: begin
        gen_valid = 1'b1;
        gen_char  = CHAR_DOT;
      end
      default: begin
        cell_ctrl.mode = CELL_HOLD;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    neg_d   = neg_q;
    pidx_d  = pidx_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    conv_d  = conv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_ok) begin
          op_d    = op_e'(in_i.data.op);
          neg_d   = v_neg;
          pidx_d  = 1'b0;
          rem_d   = REM_W'(NCELL);
          cnt_d   = CNT_W'(VALUE_BITS - 1);
          conv_d  = mag;
          state_d = (in_i.data.op == OP_HEX) ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        conv_d = {conv_q[VALUE_BITS-2:0], 1'b0};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top == '0) && (rem_q > min_digits)) begin
          rem_d = rem_q - REM_W'(1);
        end else if ((op_q == OP_HEX) || neg_q) begin
          state_d = ST_PREFIX;
        end else begin
          state_d = ST_DIGITS;
        end
      end
      ST_PREFIX: begin
        if (gen_fire) begin
          if ((op_q == OP_HEX) && !pidx_q) begin
            pidx_d = 1'b1;
          end else begin
            state_d = ST_DIGITS;
          end
        end
      end
      ST_DIGITS: begin
        if (gen_fire) begin
          rem_d = rem_q - REM_W'(1);
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end else if ((op_q == OP_FIXED) && (rem_q == REM_W'(MIN_CELLS))) begin
            state_d = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (gen_fire) begin
          state_d = ST_DIGITS;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (gen_fire) begin
      out_valid_d          = 1'b1;
      out_item_d.character = gen_char;
      out_item_d.last      = gen_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    neg_q      <= neg_d;
    pidx_q     <= pidx_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    conv_q     <= conv_d;
    out_item_q <= out_item_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;
endmodule

FILE: hdl/nta_checker.sv
// Port-level checks on the number-to-ASCII formatter, attached by bind.
// Uses nta_pkg; sees only the ports of number_to_ascii_formatter_top.
module nta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       out_last_i
);
  import nta_pkg::*;

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i &&
     (in_op_i == OP_DEC || in_op_i == OP_HEX || in_op_i == OP_FIXED)) |=> !in_ready_i)
    else $error("Input was ready again straight after an item transfer.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("Output valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_char_i) && $stable(out_last_i)))
    else $error("Output payload changed while stalled.");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((out_char_i >= CHAR_ZERO && out_char_i <= CHAR_NINE) ||
       (out_char_i >= CHAR_UPA && out_char_i <= CHAR_UPF) ||
       out_char_i == CHAR_MINUS || out_char_i == CHAR_DOT || out_char_i == CHAR_X))
    else $error("Output character outside the formatter's alphabet.");
endmodule

bind number_to_ascii_formatter_top nta_checker u_nta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.data.character),
  .out_last_i  (out_o.data.last)
);

FILE: tb/number_to_ascii_formatter_top_tb.sv
// Self-checking testbench for number_to_ascii_formatter_top: a directed table, then random
// items, with each character run predicted here and compared per transfer on out_o.
// Depends on nta_pkg, nta_stream_if and the block's RTL.
`timescale 1ns / 100ps

module number_to_ascii_formatter_top_tb;
  import nta_pkg::*;

  localparam int unsigned VALUE_BITS = 32;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 260;
  localparam int CALM_ITEMS = 30;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] value;
    bit                 typed;
    string              text;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  nta_stream_if #(.T(in_item_t))  in_if ();
  nta_stream_if #(.T(out_item_t)) out_if ();

  number_to_ascii_formatter_top #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  out_item_t expected_chars_q[$];
  stim_row_t directed_rows[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic logic [CHAR_W-1:0] nibble_char(input logic [DIGIT_W-1:0] d);
    if (d < 10) begin
      return CHAR_ZERO + {4'b0, d};
    end
    return CHAR_SEVEN + {4'b0, d};
  endfunction

  function automatic string decimal_text(input logic [63:0] x);
    string txt;
    txt = "";
    do begin
      txt = $sformatf("%c%s", nibble_char(4'(x % 10)), txt);
      x = x / 10;
    end while (x != 0);
    return txt;
  endfunction

  function automatic string render_number(input logic [OP_W-1:0] op,
                                          input logic [FIELD_W-1:0] value);
    string             txt;
    int                top;
    logic [VALUE_BITS-1:0] mag;
    logic [63:0]       frac;
    txt = "";
    top = 0;
    case (op)
      OP_DEC: txt = decimal_text({32'b0, value});
      OP_HEX: begin
        txt = $sformatf("%c%c", CHAR_ZERO, CHAR_X);
        for (int s = 0; s < VALUE_BITS / 4; s++) begin
          if (value[4*s +: 4] != 4'h0) top = s;
        end
        for (int s = top; s >= 0; s--) begin
          txt = $sformatf("%s%c", txt, nibble_char(value[4*s +: 4]));
        end
      end
      OP_FIXED: begin
        mag = value;
        if (value[VALUE_BITS-1]) begin
          mag = ~value + 1'b1;
          txt = $sformatf("%c", CHAR_MINUS);
        end
        frac = {32'b0, mag} % 1000;
        txt = $sformatf("%s%s%c%c%c%c", txt, decimal_text({32'b0, mag} / 1000), CHAR_DOT,
                        nibble_char(4'(frac / 100)), nibble_char(4'((frac / 10) % 10)),
                        nibble_char(4'(frac % 10)));
      end
      default: txt = "";
    endcase
    return txt;
  endfunction

  task automatic queue_expected_text(input string txt);
    out_item_t item;
    for (int i = 0; i < txt.len(); i++) begin
      item.character = txt[i];
      item.last = (i == txt.len() - 1);
      expected_chars_q.push_back(item);
    end
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] value,
                           input bit typed, input string text);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{op: op, value: value};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (typed) begin
      queue_expected_text(text);
    end else begin
      queue_expected_text(render_number(op, value));
    end
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] value,
                         input bit typed, input string text);
    stim_row_t row;
    row.op = op;
    row.value = value;
    row.typed = typed;
    row.text = text;
    directed_rows.push_back(row);
  endtask

  function automatic logic [FIELD_W-1:0] random_value();
    logic [FIELD_W-1:0] v;
    v = '0;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 9999);
      2: v = -$urandom_range(0, 99999);
      3: begin
        v = 32'h1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = v - 1'b1;
      end
      4: begin
        for (int s = 0; s < 8; s++) begin
          if ($urandom_range(0, 1) == 1) v[4*s +: 4] = 4'($urandom_range(1, 15));
        end
      end
      default: v = 32'h8000_0000 + $urandom_range(0, 16) - 8;
    endcase
    return v;
  endfunction

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_chars_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Unexpected character %h (last %b)", out_if.data.character,
                   out_if.data.last);
        end
      end else begin
        if (out_if.data.character !== expected_chars_q[0].character ||
            out_if.data.last !== expected_chars_q[0].last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Character mismatch: expected %h (last %b), got %h (last %b)",
                     expected_chars_q[0].character, expected_chars_q[0].last,
                     out_if.data.character, out_if.data.last);
          end
        end
        void'(expected_chars_q.pop_front());
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int                 counted;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] value;
    counted = 0;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(OP_DEC,    32'h0000_0000, 1'b1, "0");
    add_row(OP_HEX,    32'h0000_0000, 1'b1, "0x0");
    add_row(OP_FIXED,  32'h0000_0000, 1'b1, "0.000");
    add_row(OP_UNUSED, 32'h1234_5678, 1'b1, "");
    add_row(OP_DEC,    32'hFFFF_FFFF, 1'b1, "4294967295");
    add_row(OP_HEX,    32'hFFFF_FFFF, 1'b1, "0xFFFFFFFF");
    add_row(OP_FIXED,  32'hFFFF_FFFF, 1'b1, "-0.001");
    add_row(OP_FIXED,  32'h8000_0000, 1'b1, "-2147483.648");
    add_row(OP_FIXED,  32'h7FFF_FFFF, 1'b1, "2147483.647");
    add_row(OP_DEC,    32'h8000_0000, 1'b1, "2147483648");
    add_row(OP_HEX,    32'h1000_0000, 1'b1, "0x10000000");
    add_row(OP_HEX,    32'h00A0_B00C, 1'b0, "");
    add_row(OP_HEX,    32'h0000_0009, 1'b1, "0x9");
    add_row(OP_HEX,    32'h0000_000A, 1'b1, "0xA");
    add_row(OP_HEX,    32'hDEAD_BEEF, 1'b0, "");
    add_row(OP_DEC,    32'd1,         1'b1, "1");
    add_row(OP_DEC,    32'd10,        1'b0, "");
    add_row(OP_DEC,    32'd1000000000, 1'b0, "");
    add_row(OP_FIXED,  32'd999,       1'b0, "");
    add_row(OP_FIXED,  32'd1000,      1'b0, "");
    add_row(OP_FIXED,  -32'sd1000,    1'b0, "");
    add_row(OP_FIXED,  32'd12345,     1'b0, "");
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, "");
    add_row(OP_DEC,    32'h5555_AAAA, 1'b0, "");

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].text);
    end

    in_if.valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk_i);

    hold_req = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      if (counted == RANDOM_ITEMS / 2 && hold_done) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (expected_chars_q.size() != 0) @(posedge clk_i);
      end
      calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
      op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      value = random_value();
      send_item(op, value, 1'b0, "");
      if (op != OP_UNUSED) counted++;
    end

    in_if.valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
